FILE: hdl/ssd_pkg.sv
// Shared constants, types and duty-to-speed-ratio table builder for the steering controller.
package ssd_pkg;

    localparam int ERROR_FRAC_BITS  = 8;
    localparam int DUTY_TABLE_DEPTH = 801;
    localparam int DUTY_CENTRE      = 3850;
    localparam int DUTY_MIN         = 3450;
    localparam int DUTY_MAX         = 4250;
    localparam int ANGLE_LIMIT      = DUTY_MAX - DUTY_CENTRE;
    localparam int SPEED_LIMIT      = 10200;
    localparam int K_FRAC_BITS      = 14;
    localparam int GAIN_FRAC_BITS   = 8;
    localparam int GAIN_W           = 16;
    localparam int OPND_W           = 17;
    localparam int DEN_W            = 13;
    localparam int NUM_BASE_W       = 18;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

    // Q40 angle step per duty count (0.1175 deg in radians)
    localparam logic [63:0] STEP_Q = (64'd2050761575 << 28) / 64'd244140625;

    typedef logic [15:0] t_k;
    typedef t_k t_rom [DUTY_TABLE_DEPTH];

    function automatic t_k duty_k(input int unsigned n);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] den;
        logic [63:0] numr;
        logic [63:0] rem;
        logic [63:0] quo;
        longint      acc;
        int          j;
        int          b;
        x   = (64'(n) * STEP_Q) >> 10;
        t   = x;
        acc = longint'(x);
        for (j = 1; j <= 6; j++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (j)
                1: t = t / 6;
                2: t = t / 20;
                3: t = t / 42;
                4: t = t / 72;
                5: t = t / 110;
                default: t = t / 156;
            endcase
            if ((j & 1) == 1) begin
                acc = acc - longint'(t);
            end else begin
                acc = acc + longint'(t);
            end
        end
        s    = (acc < 0) ? 64'd0 : 64'(acc);
        den  = (64'd80 << 30) - 64'd37 * s;
        numr = (64'd74 * s) << 14;
        rem  = 64'd0;
        quo  = 64'd0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], numr[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return 16'(64'd16384 + quo);
    endfunction

    function automatic t_rom build_rom();
        t_rom r;
        int   i;
        int   off;
        for (i = 0; i < DUTY_TABLE_DEPTH; i++) begin
            off  = i + DUTY_MIN - DUTY_CENTRE;
            r[i] = duty_k((off < 0) ? -off : off);
        end
        return r;
    endfunction

endpackage

FILE: hdl/ssd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ssd_div #(
    parameter int NW = ssd_pkg::NUM_BASE_W + ssd_pkg::ERROR_FRAC_BITS,
    parameter int DW = ssd_pkg::DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [DW:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_q[NW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DW'(trial - {1'b0, r_den});
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: hdl/ssd_mac.sv
// Bit-serial dual multiply-accumulate: a*x + b*y, one gain bit per cycle.
module ssd_mac #(
    parameter int GW = ssd_pkg::GAIN_W,
    parameter int OW = ssd_pkg::OPND_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [GW-1:0]             i_a,
    input  logic [GW-1:0]             i_b,
    input  logic signed [OW-1:0]      i_x,
    input  logic signed [OW-1:0]      i_y,
    output logic                      o_done,
    output logic signed [GW+OW:0]     o_res
);
    localparam int RW = GW + OW + 1;
    localparam int CW = $clog2(GW);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [GW-1:0]        r_a, n_a, r_b, n_b;
    logic signed [RW-1:0] r_x, n_x, r_y, n_y, r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_x    = RW'(i_x);
            n_y    = RW'(i_y);
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = r_acc + (r_a[0] ? r_x : '0) + (r_b[0] ? r_y : '0);
            n_a   = r_a >> 1;
            n_b   = r_b >> 1;
            n_x   = r_x <<< 1;
            n_y   = r_y <<< 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(GW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
endmodule

FILE: hdl/ssd_rom.sv
// Duty-indexed speed ratio ROM, Q2.14, registered read.
module ssd_rom (
    input  logic        i_clk,
    input  logic [9:0]  i_addr,
    output logic [15:0] o_k
);
    localparam ssd_pkg::t_rom ROM = ssd_pkg::build_rom();

    logic [15:0] r_k;

    always_ff @(posedge i_clk) begin
        r_k <= ROM[i_addr];
    end

    assign o_k = r_k;
endmodule

FILE: hdl/sensor_steering_pd_differential.sv
// Top level of the six-sensor PD differential steering controller.
//  channel | direction | handshake                     | payload
//  in      | input     | i_in_valid / o_in_stall       | i_sense_1 .. i_sense_6
//  out     | output    | o_out_valid / i_out_stall     | duty, speeds, brake, error
//  cfg     | input     | i_cfg_we, i_cfg_index         | i_cfg_data
// One item at a time: the serial divider, the serial multiply-accumulate for the
// PD term, the ratio ROM, the same multiplier again for the speed, and then the
// output register; the next item is taken only after the result is loaded there.
// Reset is synchronous, active low; the ROM is constant and needs no fill.
// A result waiting in the output register does not block the next transfer in.
module sensor_steering_pd_differential #(
    parameter int ERROR_FRAC_BITS = ssd_pkg::ERROR_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_sense_1,
    input  logic [7:0]                    i_sense_2,
    input  logic [7:0]                    i_sense_3,
    input  logic [7:0]                    i_sense_4,
    input  logic [7:0]                    i_sense_5,
    input  logic [7:0]                    i_sense_6,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [12:0]                   o_steer_duty,
    output logic signed [14:0]            o_left_speed,
    output logic signed [14:0]            o_right_speed,
    output logic                          o_brake,
    output logic signed [15:0]            o_steer_error,
    input  logic                          i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssd_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int NW = ssd_pkg::NUM_BASE_W + ERROR_FRAC_BITS;
    localparam int GW = ssd_pkg::GAIN_W;
    localparam int OW = ssd_pkg::OPND_W;
    localparam int RW = GW + OW + 1;
    localparam int PD_SHIFT = ssd_pkg::GAIN_FRAC_BITS + ERROR_FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PD   = 3'd2;
    localparam logic [2:0] S_ROM  = 3'd3;
    localparam logic [2:0] S_KST  = 3'd4;
    localparam logic [2:0] S_SPD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]         r_state;
    logic [15:0]        r_kp, r_kd;
    logic signed [13:0] r_base;
    logic [10:0]        r_quiet;
    logic [4:0]         r_limit;
    logic [4:0]         r_count;
    logic               r_brake;
    logic signed [15:0] r_prev;
    logic signed [15:0] r_err;
    logic               r_neg, r_zero;
    logic [12:0]        r_duty;
    logic signed [14:0] r_scaled;
    logic               r_ovalid;
    logic [12:0]        r_o_duty;
    logic signed [14:0] r_o_left, r_o_right;
    logic               r_o_brake;
    logic signed [15:0] r_o_err;

    logic               in_xfer, out_xfer;
    logic [10:0]        total;
    logic [11:0]        lsum, rsum, dmag;
    logic [12:0]        ssum;
    logic [17:0]        num100;
    logic [NW-1:0]      div_num;
    logic               div_done;
    logic [NW-1:0]      quot;
    logic signed [15:0] err_c;
    logic [15:0]        q16;
    logic               mac_start, mac_done;
    logic [GW-1:0]      mac_a, mac_b;
    logic signed [OW-1:0] mac_x, mac_y;
    logic signed [RW-1:0] mac_res;
    logic [RW-1:0]      mag;
    logic [RW-1:0]      ang_full;
    logic [8:0]         ang;
    logic [12:0]        duty_c;
    logic [9:0]         rom_addr;
    logic [15:0]        rom_k;
    logic [RW-1:0]      smag;
    logic [14:0]        smag_c;
    logic [5:0]         cnt_inc;
    logic               load_out;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_ovalid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign total = 11'(i_sense_1) + 11'(i_sense_2) + 11'(i_sense_3)
                 + 11'(i_sense_4) + 11'(i_sense_5) + 11'(i_sense_6);
    assign lsum   = 12'(i_sense_2) * 12'd3 + 12'(i_sense_3) * 12'd7;
    assign rsum   = 12'(i_sense_4) * 12'd7 + 12'(i_sense_5) * 12'd3;
    assign ssum   = 13'(lsum) + 13'(rsum);
    assign dmag   = (lsum >= rsum) ? (lsum - rsum) : (rsum - lsum);
    assign num100 = 18'(dmag) * 18'd100;
    assign div_num = {num100, {ERROR_FRAC_BITS{1'b0}}};
    assign cnt_inc = 6'(r_count) + 6'd1;

    ssd_div #(.NW(NW), .DW(ssd_pkg::DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_num   (div_num),
        .i_den   (ssum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign q16 = quot[15:0];
    always_comb begin
        if (r_zero) begin
            err_c = '0;
        end else if (r_neg) begin
            err_c = (quot > NW'(32768)) ? 16'sh8000 : -signed'(q16);
        end else begin
            err_c = (quot > NW'(32767)) ? 16'sh7fff : signed'(q16);
        end
    end

    always_comb begin
        mac_start = 1'b0;
        mac_a = r_kp;
        mac_b = r_kd;
        mac_x = OW'(err_c);
        mac_y = OW'(err_c) - OW'(r_prev);
        if (r_state == S_DIV && div_done) begin
            mac_start = 1'b1;
        end else if (r_state == S_KST) begin
            mac_start = 1'b1;
            mac_a = rom_k;
            mac_b = '0;
            mac_x = OW'(r_base);
            mac_y = '0;
        end
    end

    ssd_mac #(.GW(GW), .OW(OW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_x     (mac_x),
        .i_y     (mac_y),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    assign mag      = mac_res[RW-1] ? RW'(-mac_res) : RW'(mac_res);
    assign ang_full = mag >> PD_SHIFT;
    assign ang      = (ang_full > RW'(ssd_pkg::ANGLE_LIMIT))
                    ? 9'(ssd_pkg::ANGLE_LIMIT) : ang_full[8:0];
    assign duty_c   = mac_res[RW-1] ? 13'(ssd_pkg::DUTY_CENTRE) - 13'(ang)
                                    : 13'(ssd_pkg::DUTY_CENTRE) + 13'(ang);
    assign rom_addr = 10'(r_duty - 13'(ssd_pkg::DUTY_MIN));

    ssd_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_k    (rom_k)
    );

    assign smag   = mag >> ssd_pkg::K_FRAC_BITS;
    assign smag_c = (smag > RW'(ssd_pkg::SPEED_LIMIT))
                  ? 15'(ssd_pkg::SPEED_LIMIT) : smag[14:0];
    assign load_out = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kp     <= '0;
            r_kd     <= '0;
            r_base   <= '0;
            r_quiet  <= 11'd50;
            r_limit  <= 5'd20;
            r_count  <= '0;
            r_brake  <= 1'b0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ssd_pkg::REG_KP:    r_kp    <= i_cfg_data;
                    ssd_pkg::REG_KD:    r_kd    <= i_cfg_data;
                    ssd_pkg::REG_BASE:  r_base  <= i_cfg_data[13:0];
                    ssd_pkg::REG_QUIET: r_quiet <= i_cfg_data[10:0];
                    ssd_pkg::REG_LIMIT: r_limit <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                if (total <= r_quiet) begin
                    if (cnt_inc >= 6'(r_limit)) begin
                        r_brake <= 1'b1;
                        r_count <= r_limit;
                    end else begin
                        r_count <= cnt_inc[4:0];
                    end
                end else if (r_count <= 5'd1) begin
                    r_count <= '0;
                    r_brake <= 1'b0;
                end else begin
                    r_count <= r_count - 5'd1;
                end
            end
            if (r_state == S_DIV && div_done) begin
                r_prev <= err_c;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (out_xfer) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (in_xfer) r_state <= S_DIV;
                S_DIV:  if (div_done) r_state <= S_PD;
                S_PD:   if (mac_done) r_state <= S_ROM;
                S_ROM:  r_state <= S_KST;
                S_KST:  r_state <= S_SPD;
                S_SPD:  if (mac_done) r_state <= S_DONE;
                S_DONE: if (load_out) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        if (in_xfer) begin
            r_neg  <= (rsum > lsum);
            r_zero <= (ssum == 13'd0);
        end
        if (r_state == S_DIV && div_done) begin
            r_err <= err_c;
        end
        if (r_state == S_PD && mac_done) begin
            r_duty <= duty_c;
        end
        if (r_state == S_SPD && mac_done) begin
            r_scaled <= mac_res[RW-1] ? -signed'(smag_c) : signed'(smag_c);
        end
        if (load_out) begin
            r_o_duty  <= r_duty;
            r_o_left  <= (r_duty < 13'(ssd_pkg::DUTY_CENTRE)) ? r_scaled : 15'(r_base);
            r_o_right <= (r_duty > 13'(ssd_pkg::DUTY_CENTRE)) ? r_scaled : 15'(r_base);
            r_o_brake <= r_brake;
            r_o_err   <= r_err;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_steer_duty  = r_o_duty;
    assign o_left_speed  = r_o_left;
    assign o_right_speed = r_o_right;
    assign o_brake       = r_o_brake;
    assign o_steer_error = r_o_err;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DIV)) else $error("transfer in did not start divide");
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_steer_duty >= 13'(ssd_pkg::DUTY_MIN)
                      && o_steer_duty <= 13'(ssd_pkg::DUTY_MAX)))
        else $error("duty out of range");
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_speed <= 15'sd10200 && o_left_speed >= -15'sd10200
                      && o_right_speed <= 15'sd10200 && o_right_speed >= -15'sd10200))
        else $error("speed out of range");
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (total <= r_quiet)) |=> (r_count <= r_limit))
        else $error("quiet count above limit");
`endif
endmodule
